// ----- hdl/sbmq_pkg.sv -----
package sbmq_pkg;

    localparam int DEF_NUM_SLOTS  = 16;
    localparam int DEF_NUM_QUEUES = 4;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int QID_W      = 2;
    localparam int DATA_IO_W  = 32;
    localparam int STATUS_W   = 2;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

endpackage

// ----- hdl/shared_buffer_multi_queue.sv -----
// Several FIFO queues share one store of NUM_SLOTS slots. Each queue is a linked list
// with head and tail pointers kept in a small queue table memory; free slots form one
// common free list. Slot values and slot links sit in two further simple dual-port RAMs
// with registered reads. An enqueue first reads the queue table and the free-slot link,
// then writes back. A dequeue that finds data adds a step in between: a second dependent
// read of the head slot's link and value, before its write back. A dequeue of an empty
// queue and an enqueue into a full store end with the lookup. The last step of a request
// waits as long as the previous result is still held on the output register. One result
// is produced per request; a new request is taken while the previous result still waits
// on the output register. Slots never yet handed out are tracked by a fill count, so no
// clearing pass follows reset.
module shared_buffer_multi_queue #(
    parameter int NUM_SLOTS  = sbmq_pkg::DEF_NUM_SLOTS,
    parameter int NUM_QUEUES = sbmq_pkg::DEF_NUM_QUEUES,
    parameter int DATA_WIDTH = sbmq_pkg::DEF_DATA_WIDTH
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_operation,
    input  logic        [sbmq_pkg::QID_W-1:0]      s_queue_id,
    input  logic signed [sbmq_pkg::DATA_IO_W-1:0]  s_data_in,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [sbmq_pkg::DATA_IO_W-1:0]  m_data_out,
    output logic        [sbmq_pkg::STATUS_W-1:0]   m_status
);

    import sbmq_pkg::*;

    localparam int PTR_W = $clog2(NUM_SLOTS + 1);
    localparam int AW    = $clog2(NUM_SLOTS);
    localparam int QAW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NUM_SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_DEQ
    } state_t;

    state_t                  state_reg, state_next;
    logic                    op_reg, op_next;
    logic [QID_W-1:0]        qid_reg, qid_next;
    logic [DATA_WIDTH-1:0]   din_reg, din_next;
    logic [PTR_W-1:0]        free_head_reg, free_head_next;
    logic [PTR_W-1:0]        fill_reg, fill_next;
    logic [NUM_QUEUES-1:0]   qvalid_reg, qvalid_next;
    logic                    m_valid_reg, m_valid_next;
    logic [DATA_IO_W-1:0]    m_data_out_reg, m_data_out_next;
    status_t                 m_status_reg, m_status_next;

    logic                    data_we, data_re;
    logic [AW-1:0]           data_waddr, data_raddr;
    logic [DATA_WIDTH-1:0]   data_rdata;
    logic                    link_we, link_re;
    logic [AW-1:0]           link_waddr, link_raddr;
    logic [PTR_W-1:0]        link_wdata, link_rdata;
    logic                    qram_we, qram_re;
    logic [QAW-1:0]          qram_waddr, qram_raddr;
    logic [2*PTR_W-1:0]      qram_wdata, qram_rdata;

    logic [31:0]             s_q_ext, q_ext;
    logic [63:0]             din_ext, dout_ext;
    logic [QAW-1:0]          q_addr;
    logic                    q_exists, q_live, out_free, fresh_slot, drained;
    logic [PTR_W-1:0]        cur_head, cur_tail, free_after;

    sbmq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_SLOTS), .AW(AW)) u_data_ram (
        .aclk  (aclk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (din_reg),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    sbmq_ram #(.WIDTH(PTR_W), .DEPTH(NUM_SLOTS), .AW(AW)) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    sbmq_ram #(.WIDTH(2 * PTR_W), .DEPTH(NUM_QUEUES), .AW(QAW)) u_queue_ram (
        .aclk  (aclk),
        .we    (qram_we),
        .waddr (qram_waddr),
        .wdata (qram_wdata),
        .re    (qram_re),
        .raddr (qram_raddr),
        .rdata (qram_rdata)
    );

    assign s_q_ext  = {{(32 - QID_W){1'b0}}, s_queue_id};
    assign q_ext    = {{(32 - QID_W){1'b0}}, qid_reg};
    assign q_addr   = q_ext[QAW-1:0];
    assign q_exists = q_ext < 32'(NUM_QUEUES);
    assign q_live   = q_exists ? qvalid_reg[q_addr] : 1'b0;
    assign cur_head = q_live ? qram_rdata[2*PTR_W-1:PTR_W] : NULL_PTR;
    assign cur_tail = q_live ? qram_rdata[PTR_W-1:0] : NULL_PTR;
    assign out_free = !m_valid_reg || m_ready;

    // slots at or above the fill count were never written, so their link is reckoned, not read
    assign fresh_slot = free_head_reg == fill_reg;
    assign free_after = fresh_slot ? free_head_reg + PTR_W'(1) : link_rdata;
    assign drained    = cur_head == cur_tail;

    assign din_ext  = {32'd0, s_data_in};
    assign dout_ext = 64'(data_rdata);

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        qid_next        = qid_reg;
        din_next        = din_reg;
        free_head_next  = free_head_reg;
        fill_next       = fill_reg;
        qvalid_next     = qvalid_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_out_next = m_data_out_reg;
        m_status_next   = m_status_reg;
        s_ready         = 1'b0;

        data_we    = 1'b0;
        data_re    = 1'b0;
        data_waddr = free_head_reg[AW-1:0];
        data_raddr = cur_head[AW-1:0];
        link_we    = 1'b0;
        link_re    = 1'b0;
        link_waddr = cur_tail[AW-1:0];
        link_wdata = free_head_reg;
        link_raddr = free_head_reg[AW-1:0];
        qram_we    = 1'b0;
        qram_re    = 1'b0;
        qram_waddr = q_addr;
        qram_wdata = {cur_head, cur_tail};
        qram_raddr = s_q_ext[QAW-1:0];

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = s_operation;
                    qid_next   = s_queue_id;
                    din_next   = din_ext[DATA_WIDTH-1:0];
                    qram_re    = 1'b1;
                    link_re    = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                if (op_reg == OP_ENQ) begin
                    if (out_free) begin
                        m_valid_next    = 1'b1;
                        m_data_out_next = '0;
                        state_next      = S_IDLE;
                        if (!q_exists || free_head_reg == NULL_PTR) begin
                            m_status_next = ST_FULL;
                        end else begin
                            m_status_next = ST_OK;
                            data_we       = 1'b1;
                            link_we       = cur_head != NULL_PTR;
                            link_wdata    = free_head_reg;
                            qram_we       = 1'b1;
                            qram_wdata    = {(cur_head == NULL_PTR) ? free_head_reg : cur_head,
                                             free_head_reg};
                            qvalid_next[q_addr] = 1'b1;
                            free_head_next = free_after;
                            if (fresh_slot) begin
                                fill_next = fill_reg + PTR_W'(1);
                            end
                        end
                    end
                end else if (cur_head == NULL_PTR) begin
                    if (out_free) begin
                        m_valid_next    = 1'b1;
                        m_data_out_next = '0;
                        m_status_next   = ST_EMPTY;
                        state_next      = S_IDLE;
                    end
                end else begin
                    data_re    = 1'b1;
                    link_re    = 1'b1;
                    link_raddr = cur_head[AW-1:0];
                    state_next = S_DEQ;
                end
            end
            S_DEQ: begin
                if (out_free) begin
                    qram_we         = 1'b1;
                    qram_wdata      = drained ? {NULL_PTR, NULL_PTR} : {link_rdata, cur_tail};
                    link_we         = 1'b1;
                    link_waddr      = cur_head[AW-1:0];
                    link_wdata      = free_head_reg;
                    free_head_next  = cur_head;
                    m_valid_next    = 1'b1;
                    m_data_out_next = dout_ext[DATA_IO_W-1:0];
                    m_status_next   = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            fill_reg      <= '0;
            qvalid_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            qvalid_reg    <= qvalid_next;
            m_valid_reg   <= m_valid_next;
        end
        op_reg         <= op_next;
        qid_reg        <= qid_next;
        din_reg        <= din_next;
        m_data_out_reg <= m_data_out_next;
        m_status_reg   <= m_status_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_data_out = m_data_out_reg;
    assign m_status   = m_status_reg;

`ifndef SYNTHESIS
    // free list head is either a recycled slot, the next fresh slot, or null
    a_free_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_head_reg <= fill_reg)
        else $error("free list head beyond fill count");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= NULL_PTR)
        else $error("fill count beyond store size");

    a_accept_look: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == S_LOOK)
        else $error("accepted transaction not looked up");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && !$past(state_reg == S_IDLE) && $past(aresetn)) |->
        (m_valid_reg && !$stable(m_status_reg + 2'd0) || m_valid_reg || $past(m_ready)))
        else $error("request finished without a result");
`endif

endmodule

// ----- hdl/sbmq_ram.sv -----
module sbmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- test/shared_buffer_multi_queue_checker.sv -----
module shared_buffer_multi_queue_checker #(
    parameter int NUM_SLOTS  = sbmq_pkg::DEF_NUM_SLOTS,
    parameter int NUM_QUEUES = sbmq_pkg::DEF_NUM_QUEUES,
    parameter int DATA_WIDTH = sbmq_pkg::DEF_DATA_WIDTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic                                  s_operation,
    input  logic        [sbmq_pkg::QID_W-1:0]     s_queue_id,
    input  logic signed [sbmq_pkg::DATA_IO_W-1:0] s_data_in,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic signed [sbmq_pkg::DATA_IO_W-1:0] m_data_out,
    input  logic        [sbmq_pkg::STATUS_W-1:0]  m_status,
    output int                                    fail_count,
    output int                                    pending
);

    import sbmq_pkg::*;

    localparam int PTR_W = $clog2(NUM_SLOTS + 1);
    localparam int AW    = $clog2(NUM_SLOTS);
    localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_SLOTS);

    typedef struct {
        logic signed [DATA_IO_W-1:0] data;
        status_t                     status;
    } outcome_t;

    logic [DATA_WIDTH-1:0] slot_value [NUM_SLOTS];
    logic [PTR_W-1:0]      slot_next  [NUM_SLOTS];
    logic [PTR_W-1:0]      head_ptr   [NUM_QUEUES];
    logic [PTR_W-1:0]      tail_ptr   [NUM_QUEUES];
    logic [PTR_W-1:0]      free_ptr;

    outcome_t outcomes_due [$];
    outcome_t due;
    int       mismatches = 0;
    int       waiting = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    function automatic void clear_lists();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_value[i] = '0;
            slot_next[i]  = (i == NUM_SLOTS - 1) ? NIL : PTR_W'(i + 1);
        end
        for (int q = 0; q < NUM_QUEUES; q++) begin
            head_ptr[q] = NIL;
            tail_ptr[q] = NIL;
        end
        free_ptr = '0;
    endfunction

    function automatic outcome_t apply_request(logic op, logic [QID_W-1:0] qid,
                                               logic signed [DATA_IO_W-1:0] din);
        outcome_t         r;
        logic [PTR_W-1:0] slot;
        r.data   = '0;
        r.status = ST_OK;
        if (op == OP_ENQ) begin
            if (int'(qid) >= NUM_QUEUES || free_ptr == NIL) begin
                r.status = ST_FULL;
            end else begin
                slot     = free_ptr;
                free_ptr = slot_next[slot[AW-1:0]];
                if (head_ptr[qid] != NIL) begin
                    slot_next[tail_ptr[qid][AW-1:0]] = slot;
                end else begin
                    head_ptr[qid] = slot;
                end
                slot_next[slot[AW-1:0]]  = NIL;
                tail_ptr[qid]            = slot;
                slot_value[slot[AW-1:0]] = din[DATA_WIDTH-1:0];
            end
        end else begin
            if (int'(qid) >= NUM_QUEUES || head_ptr[qid] == NIL) begin
                r.status = ST_EMPTY;
            end else begin
                slot          = head_ptr[qid];
                head_ptr[qid] = slot_next[slot[AW-1:0]];
                // queue drained: tail goes null with the head
                if (head_ptr[qid] == NIL) begin
                    tail_ptr[qid] = NIL;
                end
                slot_next[slot[AW-1:0]] = free_ptr;
                free_ptr                = slot;
                r.data                  = slot_value[slot[AW-1:0]];
            end
        end
        return r;
    endfunction

    task automatic report(string what, longint want, longint got);
        $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_lists();
            outcomes_due.delete();
            waiting = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (outcomes_due.size() == 0) begin
                    report("unrequested transaction status", -1, m_status);
                end else begin
                    due = outcomes_due.pop_front();
                    if (m_data_out !== due.data) begin
                        report("data_out", due.data, m_data_out);
                    end
                    if (m_status !== due.status) begin
                        report("status", due.status, m_status);
                    end
                end
            end
            if (s_valid && s_ready) begin
                outcomes_due.push_back(apply_request(s_operation, s_queue_id, s_data_in));
            end
            waiting = outcomes_due.size();
        end
    end

endmodule

// ----- test/tb_shared_buffer_multi_queue.sv -----
module tb_shared_buffer_multi_queue;
    import sbmq_pkg::*;

    localparam int RANDOM_ITEMS = 530;
    localparam int CALM_ITEMS   = 80;
    localparam int PHASE_LEN    = 60;
    localparam int HOLD_CYCLES  = 120;
    localparam int STALL_LIMIT  = 2000;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_operation = OP_ENQ;
    logic        [QID_W-1:0]     s_queue_id = '0;
    logic signed [DATA_IO_W-1:0] s_data_in = '0;
    logic                        m_ready = 1'b0;
    logic                        s_ready;
    logic                        m_valid;
    logic signed [DATA_IO_W-1:0] m_data_out;
    status_t                     m_status;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    always #4 aclk = ~aclk;

    shared_buffer_multi_queue uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_queue_id  (s_queue_id),
        .s_data_in   (s_data_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_out  (m_data_out),
        .m_status    (m_status)
    );

    shared_buffer_multi_queue_checker queue_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_queue_id  (s_queue_id),
        .s_data_in   (s_data_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_out  (m_data_out),
        .m_status    (m_status),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // offers one transaction and returns at the falling edge after it is taken
    task automatic send_item(input logic op, input logic [QID_W-1:0] qid,
                             input logic signed [DATA_IO_W-1:0] value);
        s_valid     <= 1'b1;
        s_operation <= op;
        s_queue_id  <= qid;
        s_data_in   <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic signed [DATA_IO_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // receiver side
    initial begin
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        traffic_mode_t mode;
        logic          op;
        logic [QID_W-1:0] qid;
        bit            focus;
        logic [QID_W-1:0] focus_q;
        int            enq_pct;

        mode    = MODE_FILL;
        focus   = 1'b0;
        focus_q = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty queues, dequeue payload ignored
        send_item(OP_DEQ, 2'd0, -32'sd1);
        send_item(OP_DEQ, 2'd1, 32'sh8000_0000);
        send_item(OP_DEQ, 2'd2, 32'sh7fff_ffff);
        send_item(OP_DEQ, 2'd3, '0);
        // extremes of the data field
        send_item(OP_ENQ, 2'd0, 32'sh8000_0000);
        send_item(OP_ENQ, 2'd0, 32'sh7fff_ffff);
        send_item(OP_ENQ, 2'd3, -32'sd1);
        send_item(OP_ENQ, 2'd3, '0);
        send_item(OP_ENQ, 2'd1, 32'shaaaa_aaaa);
        send_item(OP_ENQ, 2'd2, 32'sh5555_5555);
        // drain a queue, then reuse it
        send_item(OP_DEQ, 2'd0, '0);
        send_item(OP_DEQ, 2'd0, '0);
        send_item(OP_DEQ, 2'd0, '0);
        send_item(OP_ENQ, 2'd0, 32'sh1234_5678);
        send_item(OP_ENQ, 2'd0, 32'sd1);
        send_item(OP_DEQ, 2'd0, '0);
        send_item(OP_DEQ, 2'd3, '0);
        send_item(OP_DEQ, 2'd3, '0);
        send_item(OP_DEQ, 2'd1, '0);
        send_item(OP_DEQ, 2'd2, '0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % PHASE_LEN == 0 && i != 0) begin
                mode    = traffic_mode_t'($urandom_range(0, 2));
                focus   = ($urandom_range(0, 2) == 0);
                focus_q = QID_W'($urandom_range(0, 3));
            end
            if (i == RANDOM_ITEMS - CALM_ITEMS) begin
                calm = 1'b1;
            end
            if (i == 150) begin
                hold_req = 1'b1;
            end
            if (i == 300) begin
                s_valid <= 1'b0;
                @(negedge aclk);
                while (pending != 0) @(negedge aclk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end
            case (mode)
                MODE_FILL:  enq_pct = 85;
                MODE_DRAIN: enq_pct = 15;
                default:    enq_pct = 50;
            endcase
            op  = ($urandom_range(1, 100) <= enq_pct) ? OP_ENQ : OP_DEQ;
            qid = (focus && $urandom_range(0, 9) < 7) ? focus_q : QID_W'($urandom_range(0, 3));
            send_item(op, qid, pick_value());
        end
        s_valid <= 1'b0;
        calm = 1'b1;

        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/sbmq_pkg.sv
hdl/sbmq_ram.sv
hdl/shared_buffer_multi_queue.sv
test/shared_buffer_multi_queue_checker.sv
test/tb_shared_buffer_multi_queue.sv
